// File: src/dtdm_pkg.sv
`default_nettype none

package dtdm_pkg;

  // Field widths
  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int SECOND_W = 6;
  localparam int MILLIS_W = 10;
  localparam int DNUM_W   = 22;
  localparam int TMS_W    = 27;
  localparam int STATUS_W = 2;

  // Day of year fits 1..366
  localparam int DOY_W = 9;
  // Century count of a 14-bit year
  localparam int CENT_W = 8;

  // Status codes
  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_DATE_ERR = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_TIME_ERR = 2'd2;

  // Valid ranges
  localparam logic [YEAR_W-1:0]   YEAR_MAX   = 14'd9999;
  localparam logic [MONTH_W-1:0]  MONTH_MAX  = 4'd12;
  localparam logic [MONTH_W-1:0]  MONTH_FEB  = 4'd2;
  localparam logic [HOUR_W-1:0]   HOUR_LIM   = 5'd24;
  localparam logic [MINUTE_W-1:0] MINUTE_LIM = 6'd60;
  localparam logic [SECOND_W-1:0] SECOND_LIM = 6'd60;
  localparam logic [MILLIS_W-1:0] MILLIS_LIM = 10'd1000;

  // Reciprocal of 100: (y * Q100_MUL) >> Q100_SHIFT is exact for y < 2**14
  localparam logic [31:0] Q100_MUL   = 32'd167773;
  localparam int          Q100_SHIFT = 24;

  // Time scale factors
  localparam logic [TMS_W-1:0] MS_PER_HOUR   = 27'd3600000;
  localparam logic [TMS_W-1:0] MS_PER_MINUTE = 27'd60000;
  localparam logic [TMS_W-1:0] MS_PER_SECOND = 27'd1000;
  localparam logic [TMS_W-1:0] MS_PER_DAY    = 27'd86400000;

  localparam logic [DNUM_W:0] DAYS_PER_YEAR = 23'd365;

  // Length of a month in a common year; 0 for codes that are no month
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // Days in the months before m, common year
  function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
    logic [DOY_W-1:0] d;
    case (m)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

// File: src/date_time_to_day_and_ms.sv
// Converts a calendar timestamp into the proleptic Gregorian day number
// (0001-01-01 is day 1) and the milliseconds since midnight. Three register
// stages: one result per input transfer; a new item may enter every cycle in
// which in_stall is low, that is, unless every stage is full and stalled.
// The first stage forms year-1 and its century count by a reciprocal multiply,
// the second finds the leap year, checks the date and sums the time of day, the
// third adds up the day number. Each stage holds when the one after it is full
// and stalled, so out_stall reaches in_stall only when every stage holds an
// item. A bad month, day or year gives status 1, otherwise a bad time gives
// status 2; on either error both numbers read zero.
`default_nettype none

module date_time_to_day_and_ms (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire  [dtdm_pkg::YEAR_W-1:0]       in_year,
  input  wire  [dtdm_pkg::MONTH_W-1:0]      in_month,
  input  wire  [dtdm_pkg::DAY_W-1:0]        in_day,
  input  wire  [dtdm_pkg::HOUR_W-1:0]       in_hour,
  input  wire  [dtdm_pkg::MINUTE_W-1:0]     in_minute,
  input  wire  [dtdm_pkg::SECOND_W-1:0]     in_second,
  input  wire  [dtdm_pkg::MILLIS_W-1:0]     in_millis,
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic [dtdm_pkg::DNUM_W-1:0]       out_day_number,
  output logic [dtdm_pkg::TMS_W-1:0]        out_time_of_day_ms,
  output logic [dtdm_pkg::STATUS_W-1:0]     out_status
);
  import dtdm_pkg::*;

  // Stage flow control
  logic s1_v_r, s2_v_r, s3_v_r;
  logic s1_rdy, s2_rdy, s3_rdy;

  assign s3_rdy   = !s3_v_r || !out_stall;
  assign s2_rdy   = !s2_v_r || s3_rdy;
  assign s1_rdy   = !s1_v_r || s2_rdy;
  assign in_stall = !s1_rdy;

  // Stage 1: year-1, reciprocal product, range checks, time products
  logic [YEAR_W-1:0]  y_nxt;
  logic [31:0]        qprod_nxt;
  logic               ybad_nxt, mbad_nxt, tbad_nxt;
  logic [TMS_W-1:0]   h_ms_nxt, m_ms_nxt, s_ms_nxt;

  logic [YEAR_W-1:0]  s1_y_r;
  logic [31:0]        s1_qprod_r;
  logic               s1_ybad_r, s1_mbad_r, s1_tbad_r;
  logic [MONTH_W-1:0] s1_month_r;
  logic [DAY_W-1:0]   s1_day_r;
  logic [TMS_W-1:0]   s1_h_ms_r, s1_m_ms_r, s1_s_ms_r;

  always_comb begin
    y_nxt     = in_year - YEAR_W'(1);
    qprod_nxt = 32'(y_nxt) * Q100_MUL;
    ybad_nxt  = (in_year == '0) || (in_year > YEAR_MAX);
    mbad_nxt  = (in_month == '0) || (in_month > MONTH_MAX);
    tbad_nxt  = (in_hour >= HOUR_LIM) || (in_minute >= MINUTE_LIM) ||
                (in_second >= SECOND_LIM) || (in_millis >= MILLIS_LIM);
    h_ms_nxt  = TMS_W'(TMS_W'(in_hour) * MS_PER_HOUR);
    m_ms_nxt  = TMS_W'(TMS_W'(in_minute) * MS_PER_MINUTE);
    s_ms_nxt  = TMS_W'(TMS_W'(in_second) * MS_PER_SECOND) + TMS_W'(in_millis);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_rdy) begin
      s1_v_r <= in_valid;
    end
    if (s1_rdy && in_valid) begin
      s1_y_r     <= y_nxt;
      s1_qprod_r <= qprod_nxt;
      s1_ybad_r  <= ybad_nxt;
      s1_mbad_r  <= mbad_nxt;
      s1_tbad_r  <= tbad_nxt;
      s1_month_r <= in_month;
      s1_day_r   <= in_day;
      s1_h_ms_r  <= h_ms_nxt;
      s1_m_ms_r  <= m_ms_nxt;
      s1_s_ms_r  <= s_ms_nxt;
    end
  end

  // Stage 2: leap year, date check, day of year, time sum
  logic [CENT_W-1:0]  qy_nxt;
  logic [YEAR_W-1:0]  ry_nxt;
  logic               leap_nxt, dbad_nxt;
  logic [DAY_W:0]     mlen_nxt;
  logic [DOY_W-1:0]   doy_nxt;
  logic [TMS_W-1:0]   tms_nxt;

  logic [YEAR_W-1:0]  s2_y_r;
  logic [CENT_W-1:0]  s2_qy_r;
  logic               s2_dbad_r, s2_tbad_r;
  logic [DOY_W-1:0]   s2_doy_r;
  logic [TMS_W-1:0]   s2_tms_r;

  always_comb begin
    qy_nxt   = s1_qprod_r[Q100_SHIFT +: CENT_W];
    ry_nxt   = s1_y_r - YEAR_W'(qy_nxt) * YEAR_W'(100);
    // year = y+1: divisible by 4 when y ends in 3 mod 4, a century when
    // y mod 100 is 99, and then a multiple of 400 when y/100 ends in 3 mod 4
    leap_nxt = (s1_y_r[1:0] == 2'd3) &&
               ((ry_nxt != YEAR_W'(99)) || (qy_nxt[1:0] == 2'd3));
    mlen_nxt = {1'b0, month_len(s1_month_r)} +
               (DAY_W+1)'(leap_nxt && (s1_month_r == MONTH_FEB));
    dbad_nxt = s1_ybad_r || s1_mbad_r || (s1_day_r == '0) ||
               ((DAY_W+1)'(s1_day_r) > mlen_nxt);
    doy_nxt  = days_before(s1_month_r) + DOY_W'(s1_day_r) +
               DOY_W'(leap_nxt && (s1_month_r > MONTH_FEB));
    tms_nxt  = s1_h_ms_r + s1_m_ms_r + s1_s_ms_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_rdy) begin
      s2_v_r <= s1_v_r;
    end
    if (s2_rdy && s1_v_r) begin
      s2_y_r    <= s1_y_r;
      s2_qy_r   <= qy_nxt;
      s2_dbad_r <= dbad_nxt;
      s2_tbad_r <= s1_tbad_r;
      s2_doy_r  <= doy_nxt;
      s2_tms_r  <= tms_nxt;
    end
  end

  // Stage 3: day number and status, zeroed on error
  logic [DNUM_W:0]      dsum_nxt;
  logic [STATUS_W-1:0]  status_nxt;
  logic [DNUM_W-1:0]    dnum_nxt;
  logic [TMS_W-1:0]     tms_out_nxt;

  always_comb begin
    dsum_nxt = (DNUM_W+1)'((DNUM_W+1)'(s2_y_r) * DAYS_PER_YEAR) +
               (DNUM_W+1)'(s2_y_r >> 2) - (DNUM_W+1)'(s2_qy_r) +
               (DNUM_W+1)'(s2_qy_r >> 2) + (DNUM_W+1)'(s2_doy_r);
    if (s2_dbad_r) begin
      status_nxt = STATUS_DATE_ERR;
    end else if (s2_tbad_r) begin
      status_nxt = STATUS_TIME_ERR;
    end else begin
      status_nxt = STATUS_OK;
    end
    dnum_nxt    = (status_nxt == STATUS_OK) ? dsum_nxt[DNUM_W-1:0] : '0;
    tms_out_nxt = (status_nxt == STATUS_OK) ? s2_tms_r : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (s3_rdy) begin
      s3_v_r <= s2_v_r;
    end
    if (s3_rdy && s2_v_r) begin
      out_day_number     <= dnum_nxt;
      out_time_of_day_ms <= tms_out_nxt;
      out_status         <= status_nxt;
    end
  end

  assign out_valid = s3_v_r;

endmodule

`default_nettype wire

// File: src/dtdm_checker.sv
`default_nettype none

module dtdm_checker (
  input wire                              clk,
  input wire                              rst_n,
  input wire                              out_valid,
  input wire                              out_stall,
  input wire [dtdm_pkg::DNUM_W-1:0]       out_day_number,
  input wire [dtdm_pkg::TMS_W-1:0]        out_time_of_day_ms,
  input wire [dtdm_pkg::STATUS_W-1:0]     out_status
);
  import dtdm_pkg::*;

  // A held result does not change
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_day_number) &&
      $stable(out_time_of_day_ms) && $stable(out_status))
    else $error("result changed while stalled");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  // Status is one of the three codes
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == STATUS_OK) || (out_status == STATUS_DATE_ERR) ||
      (out_status == STATUS_TIME_ERR))
    else $error("unknown status code");

  // An error result carries zeros
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != STATUS_OK) |->
      (out_day_number == '0) && (out_time_of_day_ms == '0))
    else $error("error result with non-zero fields");

  // A good result lies inside one day and after day zero
  a_ok_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STATUS_OK) |->
      (out_time_of_day_ms < MS_PER_DAY) && (out_day_number != '0))
    else $error("good result out of range");

endmodule

bind date_time_to_day_and_ms dtdm_checker u_dtdm_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_day_number     (out_day_number),
  .out_time_of_day_ms (out_time_of_day_ms),
  .out_status         (out_status)
);

`default_nettype wire

// File: bench/day_ms_check_pkg.sv
package day_ms_check_pkg;
  import dtdm_pkg::*;

  // One converted timestamp as it leaves the block
  typedef struct packed {
    logic [DNUM_W-1:0]   day_number;
    logic [TMS_W-1:0]    time_of_day_ms;
    logic [STATUS_W-1:0] status;
  } conversion_t;

  class day_ms_scoreboard;
    conversion_t expected_conversions[$];
    int errors;

    static function bit is_leap(int unsigned yr);
      return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
    endfunction

    // Days in a month of the given year; 0 for a code that names no month
    static function int unsigned month_length(int unsigned yr, int unsigned mo);
      int unsigned lens[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
      if (mo < 1 || mo > MONTH_MAX) return 0;
      if (mo == MONTH_FEB && is_leap(yr)) return 29;
      return lens[mo-1];
    endfunction

    function conversion_t predict_conversion(int unsigned yr, int unsigned mo,
                                             int unsigned dy, int unsigned hr,
                                             int unsigned mi, int unsigned se,
                                             int unsigned ms);
      conversion_t res;
      int unsigned doy;
      int unsigned prior;
      bit date_bad;
      bit time_bad;
      res = '0;
      // a bad month gives a length of 0, so any day fails it
      date_bad = (yr == 0) || (yr > YEAR_MAX) || (mo == 0) || (mo > MONTH_MAX) ||
                 (dy == 0) || (dy > month_length(yr, mo));
      time_bad = (hr >= HOUR_LIM) || (mi >= MINUTE_LIM) || (se >= SECOND_LIM) ||
                 (ms >= MILLIS_LIM);
      if (date_bad) begin
        res.status = STATUS_DATE_ERR;
      end else if (time_bad) begin
        res.status = STATUS_TIME_ERR;
      end else begin
        doy = dy;
        for (int unsigned m = 1; m < mo; m++) doy += month_length(yr, m);
        prior = yr - 1;
        res.day_number = DNUM_W'(prior * 365 + prior / 4 - prior / 100 + prior / 400 +
                                 doy);
        res.time_of_day_ms = TMS_W'(hr * 3600000 + mi * 60000 + se * 1000 + ms);
        res.status = STATUS_OK;
      end
      return res;
    endfunction

    function void note_timestamp(int unsigned yr, int unsigned mo, int unsigned dy,
                                 int unsigned hr, int unsigned mi, int unsigned se,
                                 int unsigned ms);
      expected_conversions.push_back(predict_conversion(yr, mo, dy, hr, mi, se, ms));
    endfunction

    function void check_result(logic [DNUM_W-1:0] dnum, logic [TMS_W-1:0] tms,
                               logic [STATUS_W-1:0] st);
      conversion_t want;
      if (expected_conversions.size() == 0) begin
        $error("result transfer with nothing outstanding: day %0d ms %0d status %0d",
               dnum, tms, st);
        errors++;
        return;
      end
      want = expected_conversions.pop_front();
      if (dnum !== want.day_number) begin
        $error("day_number: expected %0d, got %0d", want.day_number, dnum);
        errors++;
      end
      if (tms !== want.time_of_day_ms) begin
        $error("time_of_day_ms: expected %0d, got %0d", want.time_of_day_ms, tms);
        errors++;
      end
      if (st !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, st);
        errors++;
      end
    endfunction

    function int pending();
      return expected_conversions.size();
    endfunction
  endclass

endpackage

// File: bench/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dtdm_pkg::*;
  import day_ms_check_pkg::*;

  localparam int LATENCY      = 3;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 650;
  localparam int CALM_ITEMS   = 100;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [YEAR_W-1:0]   in_year;
  logic [MONTH_W-1:0]  in_month;
  logic [DAY_W-1:0]    in_day;
  logic [HOUR_W-1:0]   in_hour;
  logic [MINUTE_W-1:0] in_minute;
  logic [SECOND_W-1:0] in_second;
  logic [MILLIS_W-1:0] in_millis;
  logic                out_valid;
  logic                out_stall;
  logic [DNUM_W-1:0]   out_day_number;
  logic [TMS_W-1:0]    out_time_of_day_ms;
  logic [STATUS_W-1:0] out_status;

  day_ms_scoreboard sb = new();
  int cycles = 0;
  int gap_pct = 0;
  int stall_pct = 0;

  date_time_to_day_and_ms dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_year            (in_year),
    .in_month           (in_month),
    .in_day             (in_day),
    .in_hour            (in_hour),
    .in_minute          (in_minute),
    .in_second          (in_second),
    .in_millis          (in_millis),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_day_number     (out_day_number),
    .out_time_of_day_ms (out_time_of_day_ms),
    .out_status         (out_status)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Transfer monitors and run limit
  always @(posedge clk) begin
    cycles++;
    if (rst_n && in_valid && !in_stall)
      sb.note_timestamp(in_year, in_month, in_day, in_hour, in_minute, in_second,
                        in_millis);
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_day_number, out_time_of_day_ms, out_status);
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver: stall bursts of random length, started at random with stall_pct
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(negedge clk);
      if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic idle_inputs(int n);
    @(negedge clk) in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // One timestamp, held until the block takes it
  task automatic send_stamp(int unsigned yr, int unsigned mo, int unsigned dy,
                            int unsigned hr, int unsigned mi, int unsigned se,
                            int unsigned ms);
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) idle_inputs($urandom_range(1, 19));
    @(negedge clk);
    in_valid  <= 1'b1;
    in_year   <= yr[YEAR_W-1:0];
    in_month  <= mo[MONTH_W-1:0];
    in_day    <= dy[DAY_W-1:0];
    in_hour   <= hr[HOUR_W-1:0];
    in_minute <= mi[MINUTE_W-1:0];
    in_second <= se[SECOND_W-1:0];
    in_millis <= ms[MILLIS_W-1:0];
    do @(posedge clk); while (in_stall);
  endtask

  // Mostly well-formed stamps; broken ones corrupt one or two fields, or all of them
  task automatic send_random_stamp(bit broken);
    int unsigned yr, mo, dy, hr, mi, se, ms, lim;
    case ($urandom_range(9))
      0:       yr = $urandom_range(1, 99) * 100;
      1:       yr = $urandom_range(0, 1) ? $urandom_range(1, 4) : $urandom_range(9996, 9999);
      default: yr = $urandom_range(1, 9999);
    endcase
    mo = $urandom_range(1, 12);
    lim = day_ms_scoreboard::month_length(yr, mo);
    dy = $urandom_range(0, 3) == 0 ? ($urandom_range(0, 1) ? lim : 1) : $urandom_range(1, lim);
    hr = $urandom_range(0, 23);
    mi = $urandom_range(0, 59);
    se = $urandom_range(0, 59);
    ms = $urandom_range(0, 999);
    if (broken) begin
      case ($urandom_range(8))
        0: begin
          yr = $urandom; mo = $urandom; dy = $urandom; hr = $urandom;
          mi = $urandom; se = $urandom; ms = $urandom;
        end
        1: yr = $urandom_range(0, 1) ? 0 : $urandom_range(10000, 16383);
        2: mo = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(13, 15);
        3: dy = (lim < 31 && $urandom_range(0, 1)) ? $urandom_range(lim + 1, 31) : 0;
        4: hr = $urandom_range(24, 31);
        5: mi = $urandom_range(60, 63);
        6: se = $urandom_range(60, 63);
        7: ms = $urandom_range(1000, 1023);
        default: begin
          mo = $urandom_range(13, 15);
          hr = $urandom_range(24, 31);
        end
      endcase
    end
    send_stamp(yr, mo, dy, hr, mi, se, ms);
  endtask

  // Hold the sender until every outstanding result has arrived
  task automatic drain_results;
    @(negedge clk) in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_year   <= '0;
    in_month  <= '0;
    in_day    <= '0;
    in_hour   <= '0;
    in_minute <= '0;
    in_second <= '0;
    in_millis <= '0;
    repeat (8) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed: range ends, leap rule, every error and their priority
    gap_pct = 20;
    stall_pct = 15;
    send_stamp(1, 1, 1, 0, 0, 0, 0);
    send_stamp(9999, 12, 31, 23, 59, 59, 999);
    send_stamp(0, 6, 15, 12, 0, 0, 0);
    send_stamp(10000, 1, 1, 0, 0, 0, 0);
    send_stamp(16383, 15, 31, 31, 63, 63, 1023);
    send_stamp(2020, 0, 10, 1, 2, 3, 4);
    send_stamp(2020, 13, 10, 1, 2, 3, 4);
    send_stamp(2020, 15, 10, 1, 2, 3, 4);
    send_stamp(2020, 5, 0, 1, 2, 3, 4);
    send_stamp(2021, 4, 31, 1, 2, 3, 4);
    send_stamp(2000, 2, 29, 6, 30, 0, 500);
    send_stamp(1900, 2, 29, 6, 30, 0, 500);
    send_stamp(2004, 2, 29, 6, 30, 0, 500);
    send_stamp(2023, 2, 29, 6, 30, 0, 500);
    send_stamp(2000, 2, 30, 6, 30, 0, 500);
    send_stamp(2024, 12, 31, 0, 0, 0, 1);
    send_stamp(1999, 7, 4, 24, 0, 0, 0);
    send_stamp(1999, 7, 4, 31, 0, 0, 0);
    send_stamp(1999, 7, 4, 0, 60, 0, 0);
    send_stamp(1999, 7, 4, 0, 63, 0, 0);
    send_stamp(1999, 7, 4, 0, 0, 60, 0);
    send_stamp(1999, 7, 4, 0, 0, 63, 0);
    send_stamp(1999, 7, 4, 0, 0, 0, 1000);
    send_stamp(1999, 7, 4, 0, 0, 0, 1023);
    send_stamp(1999, 13, 4, 31, 0, 0, 0);
    drain_results();

    // Random: idling rates change every hundred items, calm at the end
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) drain_results();
      if (i >= RANDOM_ITEMS - CALM_ITEMS) begin
        gap_pct = 0;
        stall_pct = 0;
      end else if (i % 100 == 0) begin
        case ($urandom_range(2))
          0: begin gap_pct = 0;  stall_pct = 0;  end
          1: begin gap_pct = 10; stall_pct = 10; end
          default: begin gap_pct = 35; stall_pct = 35; end
        endcase
      end
      send_random_stamp($urandom_range(99) < 30);
    end

    drain_results();
    repeat (LATENCY + 5) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: files.f
src/dtdm_pkg.sv
src/date_time_to_day_and_ms.sv
src/dtdm_checker.sv
bench/day_ms_check_pkg.sv
bench/tb_top.sv
